>>> sv/acl_pkg.sv
// Shared types, constants and tables for the arc chord linearizer.
// Used by every module of the block except acl_div; depends on nothing.
`default_nettype none
package acl_pkg;

   localparam int MAX_SEGMENTS = 64;

   localparam logic [30:0]        TOL_RESET   = 31'd655;
   localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
   localparam logic signed [34:0] HALF_TURN   = 35'sd2147483648;
   localparam logic signed [34:0] QUARTER     = 35'sd1073741824;
   localparam logic [32:0]        FULL_TURN   = 33'h1_0000_0000;
   localparam logic signed [63:0] ROUND_HALF  = 64'sd536870912;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic signed [31:0] center_off_i;
      logic signed [31:0] center_off_j;
      logic               clockwise;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               last;
      logic               clamped;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_VEC0, S_VEC0_W, S_VEC1, S_VEC1_W, S_SWEEP, S_CHK,
      S_MUL_I, S_MUL_J, S_MAG, S_SQRT, S_SQRT_W, S_NEED,
      S_CDIV, S_CDIV_W, S_CROT, S_CROT_W, S_CMUL, S_CCMP,
      S_ODIV, S_ODIV_W, S_MUL_X, S_MUL_Y, S_VY,
      S_STEP, S_PROT, S_PROT_W, S_EMIT, S_END
   } state_type;

   typedef enum logic [1:0] {
      SRC_A0, SRC_A1, SRC_CNT, SRC_PT
   } cordic_src_type;

   typedef enum logic [2:0] {
      MUL_II, MUL_JJ, MUL_XK, MUL_YK, MUL_RC
   } mul_sel_type;

   typedef enum logic {
      DIV_CNT, DIV_OUT
   } div_sel_type;

   typedef struct packed {
      logic           load;
      logic           cordic_start;
      cordic_src_type cordic_src;
      logic           div_start;
      div_sel_type    div_sel;
      logic           mul_en;
      mul_sel_type    mul_sel;
      logic           mag_ld;
      logic           mag_add;
      logic           sqrt_start;
      logic           a0_ld;
      logic           a1_ld;
      logic           sweep_ld;
      logic           need_ld;
      logic           c_ld;
      logic           n_inc;
      logic           clamp_set;
      logic           acc_init;
      logic           vx_ld;
      logic           vy_ld;
      logic           acc_step;
      logic           pt_ld;
      logic           end_ld;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic div_done;
      logic sqrt_done;
      logic sweep_zero;
      logic fits;
      logic n_at_max;
      logic last;
   } status_type;

   // arctan(2^-k) in binary turns
   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] v;
      case (k)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> sv/acl_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on acl_pkg (arctangent table, angle constants).
`default_nettype none
module acl_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               vectoring,
   input  wire logic signed [63:0] x_in,
   input  wire logic signed [63:0] y_in,
   input  wire logic [31:0]        z_in,
   output logic signed [63:0]      x_out,
   output logic signed [63:0]      y_out,
   output logic [31:0]             z_out,
   output logic                    done
);
   logic signed [63:0] x_ff, x_in_v, y_ff, y_in_v;
   logic signed [34:0] z_ff, z_in_v;
   logic [4:0]         cnt_ff, cnt_in;
   logic               run_ff, run_in, done_ff, done_in, vec_ff, vec_in;

   always_comb begin
      logic signed [63:0] dx, dy;
      logic signed [34:0] zs, at;
      logic               up;
      x_in_v  = x_ff;
      y_in_v  = y_ff;
      z_in_v  = z_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      vec_in  = vec_ff;
      done_in = 1'b0;
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      at = {3'b000, acl_pkg::atan_turn(cnt_ff)};
      up = vec_ff ? y_ff[63] : ~z_ff[34];
      zs = {{3{z_in[31]}}, z_in};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         vec_in = vectoring;
         x_in_v = x_in;
         y_in_v = y_in;
         if (vectoring) begin
            z_in_v = '0;
            if (x_in < 0) begin
               x_in_v = -x_in;
               y_in_v = -y_in;
               z_in_v = acl_pkg::HALF_TURN;
            end
         end else begin
            z_in_v = zs;
            if (zs > acl_pkg::QUARTER) begin
               x_in_v = -x_in;
               y_in_v = -y_in;
               z_in_v = zs - acl_pkg::HALF_TURN;
            end else if (zs < -acl_pkg::QUARTER) begin
               x_in_v = -x_in;
               y_in_v = -y_in;
               z_in_v = zs + acl_pkg::HALF_TURN;
            end
         end
      end else if (run_ff) begin
         if (up) begin
            x_in_v = x_ff - dx;
            y_in_v = y_ff + dy;
            z_in_v = z_ff - at;
         end else begin
            x_in_v = x_ff + dx;
            y_in_v = y_ff - dy;
            z_in_v = z_ff + at;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         vec_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
         vec_ff  <= vec_in;
      end
      x_ff <= x_in_v;
      y_ff <= y_in_v;
      z_ff <= z_in_v;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff[31:0];
   assign done  = done_ff;
endmodule
`default_nettype wire

>>> sv/acl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// 33-bit dividend, narrow divisor; no package dependency.
`default_nettype none
module acl_div #(
   parameter int DVS_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [32:0]      dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic [32:0]           quotient,
   output logic [DVS_W-1:0]      remainder,
   output logic                  done
);
   logic [32:0]      q_ff, q_in;
   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;

   always_comb begin
      logic [DVS_W:0] trial;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[32]};
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[31:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            q_in   = {q_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = q_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule
`default_nettype wire

>>> sv/acl_datapath.sv
// Datapath: operand registers, shared multiplier, square root, CORDIC and divider.
// Depends on acl_pkg, acl_cordic and acl_div.
`default_nettype none
module acl_datapath #(
   parameter int MAX_SEGMENTS = acl_pkg::MAX_SEGMENTS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire acl_pkg::req_type    req_payload,
   input  wire logic                csr_we,
   input  wire logic [30:0]         csr_wdata,
   input  wire acl_pkg::cmd_type    cmd,
   output acl_pkg::status_type      status,
   output acl_pkg::rsp_type         rsp_payload
);
   localparam int NW = $clog2(MAX_SEGMENTS + 1);
   localparam int DW = NW + 1;
   localparam int QW = 33 + NW;

   logic [30:0]        tol_ff;
   acl_pkg::req_type   in_ff;
   logic signed [32:0] cx_ff, cy_ff;
   logic               full_ff, zero_r_ff, v1zero_ff;
   logic [31:0]        a0_ff, a1_ff;
   logic [32:0]        absw_ff;
   logic               sign_ff, szero_ff;
   logic signed [67:0] prod_ff;
   logic [63:0]        mag_ff;
   logic [63:0]        sq_rem_ff, sq_rem_in, sq_root_ff, sq_root_in;
   logic [4:0]         sq_cnt_ff, sq_cnt_in;
   logic               sq_run_ff, sq_run_in, sq_done_ff, sq_done_in;
   logic [31:0]        r_ff;
   logic [61:0]        need_ff;
   logic [NW-1:0]      n_ff, k_ff, acc_r_ff;
   logic               clamp_ff;
   logic signed [32:0] c_ff;
   logic [32:0]        q0_ff;
   logic [NW-1:0]      r0_ff;
   logic [QW-1:0]      acc_q_ff;
   logic signed [63:0] vx0_ff, vy0_ff;
   acl_pkg::rsp_type   out_ff;

   logic signed [63:0] cor_x, cor_y, cor_xo, cor_yo;
   logic [31:0]        cor_z, cor_zo;
   logic               cor_vec, cor_done;
   logic [32:0]        div_q;
   logic [DW-1:0]      div_dvs, div_rem;
   logic               div_done;
   logic signed [33:0] mul_a, mul_b;
   logic signed [32:0] neg_i, neg_j;
   logic signed [33:0] dxe, dye;
   logic [31:0]        angle;

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] res;
      if (v > 36'sd2147483647)       res = 32'h7FFF_FFFF;
      else if (v < -36'sd2147483648) res = 32'h8000_0000;
      else                           res = v[31:0];
      return res;
   endfunction

   assign neg_i = -$signed({in_ff.center_off_i[31], in_ff.center_off_i});
   assign neg_j = -$signed({in_ff.center_off_j[31], in_ff.center_off_j});
   assign dxe   = $signed({{2{in_ff.end_x[31]}}, in_ff.end_x}) - $signed({cx_ff[32], cx_ff});
   assign dye   = $signed({{2{in_ff.end_y[31]}}, in_ff.end_y}) - $signed({cy_ff[32], cy_ff});
   assign angle = sign_ff ? (32'd0 - acc_q_ff[31:0]) : acc_q_ff[31:0];

   // CORDIC operand select
   always_comb begin
      cor_vec = 1'b0;
      cor_z   = div_q[31:0];
      case (cmd.cordic_src)
         acl_pkg::SRC_A0: begin
            cor_vec = 1'b1;
            cor_x   = 64'(neg_i) <<< 28;
            cor_y   = 64'(neg_j) <<< 28;
         end
         acl_pkg::SRC_A1: begin
            cor_vec = 1'b1;
            cor_x   = 64'(dxe) <<< 28;
            cor_y   = 64'(dye) <<< 28;
         end
         acl_pkg::SRC_CNT: begin
            cor_x = 64'(acl_pkg::CORDIC_K);
            cor_y = '0;
         end
         acl_pkg::SRC_PT: begin
            cor_x = vx0_ff;
            cor_y = vy0_ff;
            cor_z = angle;
         end
         default: begin
            cor_x = '0;
            cor_y = '0;
         end
      endcase
   end

   acl_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.cordic_start),
      .vectoring (cor_vec),
      .x_in      (cor_x),
      .y_in      (cor_y),
      .z_in      (cor_z),
      .x_out     (cor_xo),
      .y_out     (cor_yo),
      .z_out     (cor_zo),
      .done      (cor_done)
   );

   assign div_dvs = (cmd.div_sel == acl_pkg::DIV_CNT) ? {n_ff, 1'b0} : {1'b0, n_ff};

   acl_div #(.DVS_W(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (absw_ff),
      .divisor   (div_dvs),
      .quotient  (div_q),
      .remainder (div_rem),
      .done      (div_done)
   );

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         acl_pkg::MUL_II: begin
            mul_a = {{2{in_ff.center_off_i[31]}}, in_ff.center_off_i};
            mul_b = mul_a;
         end
         acl_pkg::MUL_JJ: begin
            mul_a = {{2{in_ff.center_off_j[31]}}, in_ff.center_off_j};
            mul_b = mul_a;
         end
         acl_pkg::MUL_XK: begin
            mul_a = {neg_i[32], neg_i};
            mul_b = acl_pkg::CORDIC_K;
         end
         acl_pkg::MUL_YK: begin
            mul_a = {neg_j[32], neg_j};
            mul_b = acl_pkg::CORDIC_K;
         end
         acl_pkg::MUL_RC: begin
            mul_a = {2'b00, r_ff};
            mul_b = {c_ff[32], c_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // bit-pair square root, two radicand bits per cycle
   always_comb begin
      logic [63:0] bitv, trial;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      sq_cnt_in  = sq_cnt_ff;
      sq_run_in  = sq_run_ff;
      sq_done_in = 1'b0;
      bitv  = 64'd1 << (6'd62 - {sq_cnt_ff, 1'b0});
      trial = sq_root_ff + bitv;
      if (cmd.sqrt_start) begin
         sq_rem_in  = mag_ff;
         sq_root_in = '0;
         sq_cnt_in  = '0;
         sq_run_in  = 1'b1;
      end else if (sq_run_ff) begin
         if (sq_rem_ff >= trial) begin
            sq_rem_in  = sq_rem_ff - trial;
            sq_root_in = (sq_root_ff >> 1) + bitv;
         end else begin
            sq_root_in = sq_root_ff >> 1;
         end
         sq_cnt_in = sq_cnt_ff + 5'd1;
         if (sq_cnt_ff == 5'd31) begin
            sq_run_in  = 1'b0;
            sq_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= acl_pkg::TOL_RESET;
         sq_cnt_ff  <= '0;
         sq_run_ff  <= 1'b0;
         sq_done_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            tol_ff <= csr_wdata;
         end
         sq_cnt_ff  <= sq_cnt_in;
         sq_run_ff  <= sq_run_in;
         sq_done_ff <= sq_done_in;
      end
   end

   always_ff @(posedge clock) begin
      logic [31:0]        mn;
      logic [32:0]        d;
      logic [NW:0]        sum_r;
      logic               carry;
      logic signed [63:0] rx, ry;
      mn    = ({1'b0, tol_ff} < r_ff) ? {1'b0, tol_ff} : r_ff;
      d     = {1'b0, a1_ff - a0_ff};
      sum_r = {1'b0, acc_r_ff} + {1'b0, r0_ff};
      carry = (sum_r >= {1'b0, n_ff});
      rx    = (cor_xo + acl_pkg::ROUND_HALF) >>> 30;
      ry    = (cor_yo + acl_pkg::ROUND_HALF) >>> 30;

      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;

      if (cmd.load) begin
         in_ff     <= req_payload;
         cx_ff     <= $signed({req_payload.start_x[31], req_payload.start_x})
                    + $signed({req_payload.center_off_i[31], req_payload.center_off_i});
         cy_ff     <= $signed({req_payload.start_y[31], req_payload.start_y})
                    + $signed({req_payload.center_off_j[31], req_payload.center_off_j});
         full_ff   <= (req_payload.end_x == req_payload.start_x)
                    && (req_payload.end_y == req_payload.start_y);
         zero_r_ff <= (req_payload.center_off_i == '0) && (req_payload.center_off_j == '0);
         clamp_ff  <= 1'b0;
      end
      // end point sitting on the center has angle zero
      if (cmd.a0_ld) begin
         a0_ff     <= cor_zo;
         v1zero_ff <= (dxe == '0) && (dye == '0);
      end
      if (cmd.a1_ld) begin
         a1_ff <= v1zero_ff ? 32'd0 : cor_zo;
      end
      if (cmd.sweep_ld) begin
         if (zero_r_ff) begin
            szero_ff <= 1'b1;
            sign_ff  <= 1'b0;
            absw_ff  <= '0;
         end else if (full_ff) begin
            szero_ff <= 1'b0;
            sign_ff  <= in_ff.clockwise;
            absw_ff  <= acl_pkg::FULL_TURN;
         end else if (in_ff.clockwise) begin
            szero_ff <= (d == '0);
            sign_ff  <= 1'b1;
            absw_ff  <= acl_pkg::FULL_TURN - d;
         end else begin
            szero_ff <= (d == '0);
            sign_ff  <= 1'b0;
            absw_ff  <= d;
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.mag_ld) begin
         mag_ff <= prod_ff[63:0];
      end else if (cmd.mag_add) begin
         mag_ff <= mag_ff + prod_ff[63:0];
      end
      if (sq_done_ff) begin
         r_ff <= sq_root_ff[31:0] + 32'(sq_rem_ff > sq_root_ff);
      end
      if (cmd.need_ld) begin
         need_ff <= {r_ff - mn, 30'd0};
         n_ff    <= NW'(1);
      end else if (cmd.n_inc) begin
         n_ff <= n_ff + NW'(1);
      end
      if (cmd.clamp_set) begin
         clamp_ff <= 1'b1;
      end
      if (cmd.c_ld) begin
         c_ff <= cor_xo[32:0];
      end
      if (cmd.acc_init) begin
         q0_ff    <= div_q;
         r0_ff    <= div_rem[NW-1:0];
         acc_q_ff <= '0;
         acc_r_ff <= '0;
         k_ff     <= '0;
      end else if (cmd.acc_step) begin
         acc_r_ff <= carry ? NW'(sum_r - {1'b0, n_ff}) : sum_r[NW-1:0];
         acc_q_ff <= acc_q_ff + QW'(q0_ff) + QW'(carry);
         k_ff     <= k_ff + NW'(1);
      end
      if (cmd.vx_ld) begin
         vx0_ff <= prod_ff[63:0];
      end
      if (cmd.vy_ld) begin
         vy0_ff <= prod_ff[63:0];
      end
      if (cmd.pt_ld) begin
         out_ff.point_x <= sat32($signed({{3{cx_ff[32]}}, cx_ff}) + $signed(rx[35:0]));
         out_ff.point_y <= sat32($signed({{3{cy_ff[32]}}, cy_ff}) + $signed(ry[35:0]));
         out_ff.point_z <= in_ff.end_z;
         out_ff.last    <= (k_ff == n_ff);
         out_ff.clamped <= clamp_ff;
      end else if (cmd.end_ld) begin
         out_ff.point_x <= in_ff.end_x;
         out_ff.point_y <= in_ff.end_y;
         out_ff.point_z <= in_ff.end_z;
         out_ff.last    <= 1'b1;
         out_ff.clamped <= 1'b0;
      end
   end

   assign status.cordic_done = cor_done;
   assign status.div_done    = div_done;
   assign status.sqrt_done   = sq_done_ff;
   assign status.sweep_zero  = szero_ff;
   assign status.fits        = (prod_ff >= $signed({6'd0, need_ff}));
   assign status.n_at_max    = (n_ff == NW'(MAX_SEGMENTS));
   assign status.last        = out_ff.last;
   assign rsp_payload        = out_ff;
endmodule
`default_nettype wire

>>> sv/acl_ctrl.sv
// Controller state machine sequencing the arc linearizer datapath.
// Depends on acl_pkg (state, command and status types).
`default_nettype none
module acl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire acl_pkg::status_type status,
   output acl_pkg::cmd_type         cmd,
   output logic                     busy,
   output logic                     rsp_valid
);
   acl_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acl_pkg::S_IDLE:   if (start) state_in = acl_pkg::S_VEC0;
         acl_pkg::S_VEC0:   state_in = acl_pkg::S_VEC0_W;
         acl_pkg::S_VEC0_W: if (status.cordic_done) state_in = acl_pkg::S_VEC1;
         acl_pkg::S_VEC1:   state_in = acl_pkg::S_VEC1_W;
         acl_pkg::S_VEC1_W: if (status.cordic_done) state_in = acl_pkg::S_SWEEP;
         acl_pkg::S_SWEEP:  state_in = acl_pkg::S_CHK;
         acl_pkg::S_CHK:    state_in = status.sweep_zero ? acl_pkg::S_END : acl_pkg::S_MUL_I;
         acl_pkg::S_MUL_I:  state_in = acl_pkg::S_MUL_J;
         acl_pkg::S_MUL_J:  state_in = acl_pkg::S_MAG;
         acl_pkg::S_MAG:    state_in = acl_pkg::S_SQRT;
         acl_pkg::S_SQRT:   state_in = acl_pkg::S_SQRT_W;
         acl_pkg::S_SQRT_W: if (status.sqrt_done) state_in = acl_pkg::S_NEED;
         acl_pkg::S_NEED:   state_in = acl_pkg::S_CDIV;
         acl_pkg::S_CDIV:   state_in = acl_pkg::S_CDIV_W;
         acl_pkg::S_CDIV_W: if (status.div_done) state_in = acl_pkg::S_CROT;
         acl_pkg::S_CROT:   state_in = acl_pkg::S_CROT_W;
         acl_pkg::S_CROT_W: if (status.cordic_done) state_in = acl_pkg::S_CMUL;
         acl_pkg::S_CMUL:   state_in = acl_pkg::S_CCMP;
         acl_pkg::S_CCMP: begin
            if (status.fits || status.n_at_max) state_in = acl_pkg::S_ODIV;
            else                                state_in = acl_pkg::S_CDIV;
         end
         acl_pkg::S_ODIV:   state_in = acl_pkg::S_ODIV_W;
         acl_pkg::S_ODIV_W: if (status.div_done) state_in = acl_pkg::S_MUL_X;
         acl_pkg::S_MUL_X:  state_in = acl_pkg::S_MUL_Y;
         acl_pkg::S_MUL_Y:  state_in = acl_pkg::S_VY;
         acl_pkg::S_VY:     state_in = acl_pkg::S_STEP;
         acl_pkg::S_STEP:   state_in = acl_pkg::S_PROT;
         acl_pkg::S_PROT:   state_in = acl_pkg::S_PROT_W;
         acl_pkg::S_PROT_W: if (status.cordic_done) state_in = acl_pkg::S_EMIT;
         acl_pkg::S_EMIT:   state_in = status.last ? acl_pkg::S_IDLE : acl_pkg::S_STEP;
         acl_pkg::S_END:    state_in = acl_pkg::S_EMIT;
         default:           state_in = acl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.cordic_src = acl_pkg::SRC_A0;
      cmd.div_sel    = acl_pkg::DIV_CNT;
      cmd.mul_sel    = acl_pkg::MUL_II;
      case (state_ff)
         acl_pkg::S_IDLE:   cmd.load = start;
         acl_pkg::S_VEC0:   cmd.cordic_start = 1'b1;
         acl_pkg::S_VEC0_W: cmd.a0_ld = status.cordic_done;
         acl_pkg::S_VEC1: begin
            cmd.cordic_start = 1'b1;
            cmd.cordic_src   = acl_pkg::SRC_A1;
         end
         acl_pkg::S_VEC1_W: cmd.a1_ld = status.cordic_done;
         acl_pkg::S_SWEEP:  cmd.sweep_ld = 1'b1;
         acl_pkg::S_MUL_I:  cmd.mul_en = 1'b1;
         acl_pkg::S_MUL_J: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = acl_pkg::MUL_JJ;
            cmd.mag_ld  = 1'b1;
         end
         acl_pkg::S_MAG:    cmd.mag_add = 1'b1;
         acl_pkg::S_SQRT:   cmd.sqrt_start = 1'b1;
         acl_pkg::S_NEED:   cmd.need_ld = 1'b1;
         acl_pkg::S_CDIV:   cmd.div_start = 1'b1;
         acl_pkg::S_CROT: begin
            cmd.cordic_start = 1'b1;
            cmd.cordic_src   = acl_pkg::SRC_CNT;
         end
         acl_pkg::S_CROT_W: cmd.c_ld = status.cordic_done;
         acl_pkg::S_CMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = acl_pkg::MUL_RC;
         end
         acl_pkg::S_CCMP: begin
            cmd.clamp_set = ~status.fits & status.n_at_max;
            cmd.n_inc     = ~status.fits & ~status.n_at_max;
         end
         acl_pkg::S_ODIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = acl_pkg::DIV_OUT;
         end
         acl_pkg::S_ODIV_W: begin
            cmd.div_sel  = acl_pkg::DIV_OUT;
            cmd.acc_init = status.div_done;
         end
         acl_pkg::S_MUL_X: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = acl_pkg::MUL_XK;
         end
         acl_pkg::S_MUL_Y: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = acl_pkg::MUL_YK;
            cmd.vx_ld   = 1'b1;
         end
         acl_pkg::S_VY:     cmd.vy_ld = 1'b1;
         acl_pkg::S_STEP:   cmd.acc_step = 1'b1;
         acl_pkg::S_PROT: begin
            cmd.cordic_start = 1'b1;
            cmd.cordic_src   = acl_pkg::SRC_PT;
         end
         acl_pkg::S_PROT_W: begin
            cmd.cordic_src = acl_pkg::SRC_PT;
            cmd.pt_ld      = status.cordic_done;
         end
         acl_pkg::S_END:    cmd.end_ld = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != acl_pkg::S_IDLE);
   assign rsp_valid = (state_ff == acl_pkg::S_EMIT);
endmodule
`default_nettype wire

>>> sv/arc_chord_linearizer.sv
// Arc chord linearizer top level: controller plus datapath; depends on acl_pkg.
// Sequence: setup computes two CORDIC angles and a square root, then each segment count tried
// takes a divide and a CORDIC rotation, then the point angles are set up, and one strobe is
// given per point (one CORDIC rotation per point); zero radius or zero sweep strobes the end
// point only. Throughput: one arc at a time, next start taken once busy falls; results cannot
// be stalled. Sync reset idles the sequencer, chord_tolerance = 655.
`default_nettype none
module arc_chord_linearizer #(
   parameter int MAX_SEGMENTS = acl_pkg::MAX_SEGMENTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire acl_pkg::req_type req_payload,
   output logic                  rsp_valid,
   output acl_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_we,
   input  wire logic [30:0]      csr_wdata
);
   acl_pkg::cmd_type    cmd;
   acl_pkg::status_type status;

   acl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   acl_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside an arc");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |=> !busy)
      else $error("still busy after final point");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("start transfer not taken");

   a_no_back2back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("points strobed on consecutive cycles");
endmodule
`default_nettype wire
